// File: hdl/pfa_pkg.sv
// Shared types and constants for the prime field arithmetic unit.
package pfa_pkg;

  localparam int FIELD_WIDTH = 64;
  localparam int CNT_W       = $clog2(FIELD_WIDTH);
  localparam logic [63:0] MODULUS_RESET = 64'hFFFF_FFFF_0000_0001;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_NEG = 3'd3,
    MODE_DBL = 3'd4,
    MODE_SQR = 3'd5,
    MODE_INV = 3'd6
  } mode_t;

  // operand pair loaded into the serial multiplier
  typedef enum logic [2:0] {
    MS_RED_A,
    MS_RED_B,
    MS_XY,
    MS_XX,
    MS_TT,
    MS_XT
  } mul_sel_t;

  typedef enum logic [1:0] {
    TS_ACC,
    TS_ALU,
    TS_ZERO,
    TS_ONE
  } t_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_A,
    ST_RED_A,
    ST_LD_B,
    ST_RED_B,
    ST_EXEC,
    ST_MUL,
    ST_PSQ,
    ST_PCHK,
    ST_PML,
    ST_PADV,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     wr_x;
    logic     wr_y;
    logic     t_wr;
    t_src_t   t_src;
    logic [2:0] alu_mode;
    logic     exp_load;
    logic     exp_shift;
    logic     out_load;
  } pfa_cmd_t;

  typedef struct packed {
    logic p_small;
    logic x_zero;
    logic exp_bit;
    logic out_free;
  } pfa_stat_t;

endpackage

// File: hdl/prime_field_alu.sv
// Top level of the prime field arithmetic unit: stream ports, configuration and checks.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   mode, operand_a, operand_b
//  m_axis    out  m_axis_tvalid/m_axis_tready   result
//  cfg       in   cfg_we                        modulus
//
// One item at a time. Reduction, multiply, square and inverse run on one bit-serial
// modular multiplier that takes a load step and then one multiplier bit per cycle
// (FIELD_WIDTH steps). Both operands are reduced first; add, subtract, negate and
// double then use modular add and subtract logic. Inverse adds up to FIELD_WIDTH
// multiply steps and FIELD_WIDTH-1 square steps.
// A modulus below two gives zero without reducing the operands.
// Reset (rst, synchronous) loads the default modulus and empties the output.
// The result waits in the output register; a new item is taken meanwhile and
// only its final write waits for that register to drain.
module prime_field_alu
  import pfa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_data,        // modulus
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,    // [2:0] mode, [66:3] operand_a, [130:67] operand_b
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata     // [63:0] result
);

  pfa_cmd_t  cmd;
  pfa_stat_t stat;

  // Sequence the reduction, operation and result write.
  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_mode  (s_axis_tdata[2:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the modulus and run the arithmetic.
  pfa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_a      (s_axis_tdata[66:3]),
    .in_b      (s_axis_tdata[130:67]),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

`ifndef SYNTHESIS
  // after a transfer in, the block is busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  // a new result appears only from a result write
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a result write");
`endif

endmodule

// File: hdl/pfa_datapath.sv
// Datapath: modulus register, operand registers, serial modular multiplier, output register.
module pfa_datapath
  import pfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  logic [63:0] in_a,
  input  logic [63:0] in_b,
  input  pfa_cmd_t    cmd,
  output pfa_stat_t   stat,
  output logic [63:0] out_data,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam int W = FIELD_WIDTH;

  logic [W-1:0] p;
  logic [W-1:0] a_raw, b_raw;
  logic [W-1:0] x, y, t, acc;
  logic [W-1:0] mcand, mplier, expo;
  logic [W-1:0] res;
  logic [W-1:0] dbl, acc_next, alu_res;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
    logic [W-1:0] d;
    d = u - v;
    if (u < v) begin
      d = d + m;
    end
    return d;
  endfunction

  // one multiplier bit: double, then add the multiplicand when the bit is set
  always_comb begin
    dbl      = add_mod(acc, acc, p);
    acc_next = mplier[W-1] ? add_mod(dbl, mcand, p) : dbl;
  end

  always_comb begin
    unique case (cmd.alu_mode)
      MODE_ADD: alu_res = add_mod(x, y, p);
      MODE_SUB: alu_res = sub_mod(x, y, p);
      MODE_NEG: alu_res = sub_mod('0, x, p);
      MODE_DBL: alu_res = add_mod(x, x, p);
      default:  alu_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= MODULUS_RESET[W-1:0];
    end else if (cfg_we) begin
      p <= cfg_data[W-1:0];
    end
  end

  // product registers take the value of the final step, written on that step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_raw <= in_a[W-1:0];
      b_raw <= in_b[W-1:0];
    end
    if (cmd.mul_start) begin
      acc <= '0;
      unique case (cmd.mul_sel)
        MS_RED_A: begin mcand <= W'(1); mplier <= a_raw; end
        MS_RED_B: begin mcand <= W'(1); mplier <= b_raw; end
        MS_XY:    begin mcand <= x;     mplier <= y;     end
        MS_XX:    begin mcand <= x;     mplier <= x;     end
        MS_TT:    begin mcand <= t;     mplier <= t;     end
        MS_XT:    begin mcand <= x;     mplier <= t;     end
        default:  begin mcand <= x;     mplier <= y;     end
      endcase
    end else if (cmd.mul_step) begin
      acc    <= acc_next;
      mplier <= {mplier[W-2:0], 1'b0};
    end
    if (cmd.wr_x) begin
      x <= acc_next;
    end
    if (cmd.wr_y) begin
      y <= acc_next;
    end
    if (cmd.t_wr) begin
      unique case (cmd.t_src)
        TS_ACC:  t <= acc_next;
        TS_ALU:  t <= alu_res;
        TS_ZERO: t <= '0;
        TS_ONE:  t <= W'(1);
        default: t <= '0;
      endcase
    end
    if (cmd.exp_load) begin
      expo <= p - W'(2);
    end else if (cmd.exp_shift) begin
      expo <= {expo[W-2:0], 1'b0};
    end
    if (cmd.out_load) begin
      res <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data      = 64'(res);
  assign stat.p_small  = (p < W'(2));
  assign stat.x_zero   = (x == '0);
  assign stat.exp_bit  = expo[W-1];
  assign stat.out_free = !out_valid || out_ready;

endmodule

// File: hdl/pfa_ctrl.sv
// Controller: sequences operand reduction, the selected operation and the result write.
module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  pfa_stat_t  stat,
  output pfa_cmd_t   cmd
);

  state_t           state, state_next;
  logic [2:0]       mode;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] ecnt, ecnt_next;
  logic             cnt_last, ecnt_last;

  assign cnt_last  = (cnt == CNT_W'(FIELD_WIDTH - 1));
  assign ecnt_last = (ecnt == CNT_W'(FIELD_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ecnt  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ecnt  <= ecnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode <= in_mode;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ecnt_next  = ecnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.alu_mode = mode;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.p_small) begin
            cmd.t_wr  = 1'b1;
            cmd.t_src = TS_ZERO;
            state_next = ST_WRITE;
          end else begin
            state_next = ST_LD_A;
          end
        end
      end
      ST_LD_A: begin
        // raw operand was captured at accept; load it into the multiplier
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_RED_A;
        cnt_next      = '0;
        state_next    = ST_RED_A;
      end
      ST_RED_A: begin
        cmd.mul_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          cmd.wr_x   = 1'b1;
          state_next = ST_LD_B;
        end
      end
      ST_LD_B: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_RED_B;
        cnt_next      = '0;
        state_next    = ST_RED_B;
      end
      ST_RED_B: begin
        cmd.mul_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          cmd.wr_y   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (mode == MODE_MUL || mode == MODE_SQR) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = (mode == MODE_MUL) ? MS_XY : MS_XX;
          state_next    = ST_MUL;
        end else if (mode == MODE_INV && !stat.x_zero) begin
          cmd.t_wr      = 1'b1;
          cmd.t_src     = TS_ONE;
          cmd.exp_load  = 1'b1;
          ecnt_next     = '0;
          state_next    = ST_PCHK;
        end else if (mode == MODE_INV) begin
          cmd.t_wr      = 1'b1;
          cmd.t_src     = TS_ZERO;
          state_next    = ST_WRITE;
        end else begin
          cmd.t_wr      = 1'b1;
          cmd.t_src     = TS_ALU;
          state_next    = ST_WRITE;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          cmd.t_wr   = 1'b1;
          cmd.t_src  = TS_ACC;
          state_next = ST_WRITE;
        end
      end
      ST_PSQ: begin
        cmd.mul_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          cmd.t_wr   = 1'b1;
          cmd.t_src  = TS_ACC;
          state_next = ST_PCHK;
        end
      end
      ST_PCHK: begin
        // t is squared for this exponent bit except before the first one
        if (stat.exp_bit) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_XT;
          state_next    = ST_PML;
        end else begin
          state_next    = ST_PADV;
        end
      end
      ST_PML: begin
        cmd.mul_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          cmd.t_wr   = 1'b1;
          cmd.t_src  = TS_ACC;
          state_next = ST_PADV;
        end
      end
      ST_PADV: begin
        cmd.exp_shift = 1'b1;
        if (ecnt_last) begin
          ecnt_next  = '0;
          state_next = ST_WRITE;
        end else begin
          ecnt_next     = ecnt + 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_TT;
          state_next    = ST_PSQ;
        end
      end
      ST_WRITE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: test/prime_field_alu_tb.sv
// Self-checking testbench for the prime field arithmetic unit.
`timescale 1ns / 1ps

module prime_field_alu_tb;
  import pfa_pkg::*;

  localparam logic [63:0] GOLDILOCKS = 64'hFFFF_FFFF_0000_0001;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [63:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;   // [2:0] mode, [66:3] operand_a, [130:67] operand_b
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;        // [63:0] result

  prime_field_alu DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the modulus the block should be using right now.
  logic [63:0] field_prime;
  logic [63:0] expected_results[$];
  int unsigned mismatches = 0;
  int unsigned unexpected = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  // Modular helpers; 65-bit sums catch the carry out of the top bit.
  function automatic logic [63:0] field_add(logic [63:0] x, logic [63:0] y, logic [63:0] p);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[63:0];
  endfunction

  function automatic logic [63:0] field_mul(logic [63:0] x, logic [63:0] y, logic [63:0] p);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return 64'(prod % {64'd0, p});
  endfunction

  function automatic logic [63:0] field_pow(logic [63:0] x, logic [63:0] e, logic [63:0] p);
    logic [63:0] acc;
    acc = 64'd1 % p;
    for (int i = 63; i >= 0; i--) begin
      acc = field_mul(acc, acc, p);
      if (e[i]) acc = field_mul(acc, x, p);
    end
    return acc;
  endfunction

  function automatic logic [63:0] field_result(logic [2:0] mode, logic [63:0] a,
                                               logic [63:0] b, logic [63:0] p);
    logic [63:0] x, y;
    if (p < 2) return '0;
    x = a % p;
    y = b % p;
    case (mode)
      MODE_ADD: return field_add(x, y, p);
      MODE_SUB: return (x >= y) ? x - y : x + (p - y);
      MODE_MUL: return field_mul(x, y, p);
      MODE_NEG: return (x == 0) ? 64'd0 : p - x;
      MODE_DBL: return field_add(x, x, p);
      MODE_SQR: return field_mul(x, x, p);
      MODE_INV: return (x == 0) ? 64'd0 : field_pow(x, p - 2, p);
      default:  return '0;
    endcase
  endfunction

  // Send one item; the sender may pause between bursts of random length.
  // Valid stays high after a transfer until the next item or a pause replaces it.
  task automatic send_item(logic [2:0] mode, logic [63:0] a, logic [63:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tdata  <= {5'd0, b, a, mode};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results.push_back(field_result(mode, a, b, field_prime));
    items_sent++;
  endtask

  // Wait for all expected results to drain, then write the modulus.
  task automatic set_modulus(logic [63:0] p);
    int guard;
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    field_prime = p;
  endtask

  // Operand mostly reduced, sometimes raw (any 64-bit value), sometimes an edge.
  function automatic logic [63:0] pick_operand(logic [63:0] p);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return v;
      1: return (p == 0) ? 0 : p - 1;
      2: return $urandom_range(0, 2);
      3: return p;
      default: return (p < 2) ? v : v % p;
    endcase
  endfunction

  // Inverse is slow; keep it rare in the random traffic.
  function automatic logic [2:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return MODE_INV;
    if (r < 8) return MODE_UNUSED;
    return 3'($urandom_range(0, 5));
  endfunction

  task automatic test_directed_edges();
    logic [63:0] pm1;
    pm1 = field_prime - 1;
    for (int m = 0; m < 8; m++) send_item(3'(m), pm1, pm1);
    for (int m = 0; m < 8; m++) send_item(3'(m), 64'd0, 64'd0);
    send_item(MODE_ADD, ALL_ONES, ALL_ONES);      // operands not reduced
    send_item(MODE_MUL, ALL_ONES, field_prime);
    send_item(MODE_INV, 64'd1, 64'd0);
    send_item(MODE_INV, ALL_ONES, ALL_ONES);
    send_item(MODE_SUB, 64'd1, pm1);
    send_item(MODE_NEG, field_prime, 64'd0);
  endtask

  task automatic test_random_items(int count);
    for (int i = 0; i < count; i++)
      send_item(pick_mode(), pick_operand(field_prime), pick_operand(field_prime));
  endtask

  task automatic test_degenerate_moduli();
    set_modulus(64'd0);
    for (int m = 0; m < 8; m++) send_item(3'(m), ALL_ONES, 64'd5);
    set_modulus(64'd1);
    for (int m = 0; m < 8; m++) send_item(3'(m), 64'd3, ALL_ONES);
    set_modulus(64'd2);
    for (int m = 0; m < 8; m++) send_item(3'(m), 64'd1, 64'd1);
    set_modulus(64'd4);
    test_random_items(10);
  endtask

  // Receiver stalls on a rotating pattern, with stall-free windows.
  logic [15:0] stall_pattern = 16'hA5F0;
  int unsigned stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) stall_pattern <= 16'($urandom);
    m_axis_tready <= (stall_phase % 256 >= 192) ? 1'b1 : !stall_pattern[stall_phase % 16];
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result %h", m_axis_tdata);
      end else begin
        logic [63:0] want;
        want = expected_results.pop_front();
        results_checked++;
        if (m_axis_tdata !== want) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("result mismatch: expected %h got %h", want, m_axis_tdata);
        end
      end
    end
  end

  initial begin
    int guard;
    field_prime = GOLDILOCKS;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_random_items(200);
    set_modulus(64'hFFFF_FFFF_FFFF_FFC5);   // largest 64-bit prime
    test_directed_edges();
    test_random_items(100);
    set_modulus(64'd5);                     // small prime
    test_random_items(60);
    set_modulus(64'd2013265921);            // 2^31 - 2^27 + 1
    test_random_items(80);
    test_degenerate_moduli();
    set_modulus(GOLDILOCKS);
    test_random_items(40);
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (expected_results.size() != 0 && guard < 500000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
    $display("Sent %0d items over eight moduli (default, extremes, degenerate);", items_sent);
    $display("checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Worst case ~600 items of slow inverse work with stalls, times margin.
  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
